@@ hw/rtl/deqs_pkg.sv @@
package deqs_pkg;

	// Field widths of the stream payloads.
	localparam int CMD_W    = 3;
	localparam int VALUE_W  = 32;
	localparam int STATUS_W = 2;
	localparam int FILL_W   = 5;
	localparam int S_TDATA_W = 40;
	localparam int M_TDATA_W = 40;

	// Request commands.
	localparam logic [CMD_W-1:0] CMD_PUSH_FRONT = 3'd0;
	localparam logic [CMD_W-1:0] CMD_PUSH_BACK  = 3'd1;
	localparam logic [CMD_W-1:0] CMD_POP_FRONT  = 3'd2;
	localparam logic [CMD_W-1:0] CMD_POP_BACK   = 3'd3;
	localparam logic [CMD_W-1:0] CMD_CONTAINS   = 3'd4;

	// Result status codes.
	localparam logic [STATUS_W-1:0] STAT_OK    = 2'd0;
	localparam logic [STATUS_W-1:0] STAT_EMPTY = 2'd1;
	localparam logic [STATUS_W-1:0] STAT_FULL  = 2'd2;

	// Store address selection.
	localparam logic [2:0] ASEL_FRONT_M1 = 3'd0;
	localparam logic [2:0] ASEL_BACK_P1  = 3'd1;
	localparam logic [2:0] ASEL_FRONT    = 3'd2;
	localparam logic [2:0] ASEL_BACK     = 3'd3;
	localparam logic [2:0] ASEL_SEARCH   = 3'd4;

	// Pointer updates.
	localparam logic [2:0] UPD_NONE   = 3'd0;
	localparam logic [2:0] UPD_PUSH_F = 3'd1;
	localparam logic [2:0] UPD_PUSH_B = 3'd2;
	localparam logic [2:0] UPD_POP_F  = 3'd3;
	localparam logic [2:0] UPD_POP_B  = 3'd4;

	typedef struct packed {
		logic                load;
		logic                wr;
		logic                rd;
		logic [2:0]          asel;
		logic [2:0]          upd;
		logic                idx_inc;
		logic                emit;
		logic                res_pop;
		logic                res_found;
		logic [STATUS_W-1:0] res_status;
	} deqs_cmd_t;

	typedef struct packed {
		logic [CMD_W-1:0] op;
		logic             empty;
		logic             full;
		logic             match;
		logic             srch_end;
		logic             out_free;
	} deqs_stat_t;

endpackage

@@ hw/rtl/deqs_ram.sv @@
module deqs_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		if (re) begin
			rdata <= mem[addr];
		end
	end

endmodule

@@ hw/rtl/deqs_ctrl.sv @@
module deqs_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  deqs_pkg::deqs_stat_t stat,
	output deqs_pkg::deqs_cmd_t  cmd
);

	import deqs_pkg::*;

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_EXEC = 2'd1;
	localparam logic [1:0] S_POP  = 2'd2;
	localparam logic [1:0] S_SRCH = 2'd3;

	logic [1:0] state_q;
	logic [1:0] state_d;

	assign in_ready = (state_q == S_IDLE);

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = S_EXEC;
				end
			end
			S_EXEC: begin
				case (stat.op)
					CMD_PUSH_FRONT, CMD_PUSH_BACK: begin
						if (stat.out_free) begin
							cmd.emit = 1'b1;
							state_d  = S_IDLE;
							if (stat.full) begin
								cmd.res_status = STAT_FULL;
							end else begin
								cmd.wr = 1'b1;
								if (stat.op == CMD_PUSH_FRONT) begin
									cmd.asel = ASEL_FRONT_M1;
									cmd.upd  = UPD_PUSH_F;
								end else begin
									cmd.asel = ASEL_BACK_P1;
									cmd.upd  = UPD_PUSH_B;
								end
							end
						end
					end
					CMD_POP_FRONT, CMD_POP_BACK: begin
						if (!stat.empty) begin
							cmd.rd   = 1'b1;
							cmd.asel = (stat.op == CMD_POP_FRONT) ? ASEL_FRONT : ASEL_BACK;
							state_d  = S_POP;
						end else if (stat.out_free) begin
							cmd.emit       = 1'b1;
							cmd.res_status = STAT_EMPTY;
							state_d        = S_IDLE;
						end
					end
					CMD_CONTAINS: begin
						if (!stat.empty) begin
							cmd.rd      = 1'b1;
							cmd.asel    = ASEL_SEARCH;
							cmd.idx_inc = 1'b1;
							state_d     = S_SRCH;
						end else if (stat.out_free) begin
							cmd.emit = 1'b1;
							state_d  = S_IDLE;
						end
					end
					default: begin
						if (stat.out_free) begin
							cmd.emit = 1'b1;
							state_d  = S_IDLE;
						end
					end
				endcase
			end
			S_POP: begin
				if (stat.out_free) begin
					cmd.emit    = 1'b1;
					cmd.res_pop = 1'b1;
					cmd.upd     = (stat.op == CMD_POP_FRONT) ? UPD_POP_F : UPD_POP_B;
					state_d     = S_IDLE;
				end
			end
			S_SRCH: begin
				if (stat.match || stat.srch_end) begin
					if (stat.out_free) begin
						cmd.emit      = 1'b1;
						cmd.res_found = 1'b1;
						state_d       = S_IDLE;
					end
				end else begin
					cmd.rd      = 1'b1;
					cmd.asel    = ASEL_SEARCH;
					cmd.idx_inc = 1'b1;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	a_emit_needs_room: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |-> stat.out_free)
		else $error("result issued while the output register is occupied");

	a_one_store_access: assert property (@(posedge clk) disable iff (!arst_n)
		!(cmd.wr && cmd.rd))
		else $error("store read and written in the same cycle");

	a_load_only_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |=> (state_q == S_EXEC))
		else $error("accepted request did not start execution");

endmodule

@@ hw/rtl/deqs_dp.sv @@
module deqs_dp #(
	parameter int DEPTH      = 16,
	parameter int DATA_WIDTH = 32
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic [deqs_pkg::CMD_W-1:0]     op_in,
	input  logic [deqs_pkg::VALUE_W-1:0]   value_in,
	input  deqs_pkg::deqs_cmd_t            cmd,
	output deqs_pkg::deqs_stat_t           stat,
	input  logic                           out_ready,
	output logic                           out_valid,
	output logic [deqs_pkg::VALUE_W-1:0]   popped_value,
	output logic                           found,
	output logic [deqs_pkg::STATUS_W-1:0]  status,
	output logic [deqs_pkg::FILL_W-1:0]    fill_level
);

	import deqs_pkg::*;

	localparam int AW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);
	localparam int SW = CW + 1;

	logic [CMD_W-1:0]      op_q;
	logic [DATA_WIDTH-1:0] value_q;
	logic [AW-1:0]         front_q;
	logic [CW-1:0]         count_q;
	logic [CW-1:0]         idx_q;
	logic [AW-1:0]         front_d;
	logic [CW-1:0]         count_d;
	logic [AW-1:0]         front_m1;
	logic [AW-1:0]         front_p1;
	logic [SW-1:0]         fc_sum;
	logic [SW-1:0]         fi_sum;
	logic [AW-1:0]         addr;
	logic [DATA_WIDTH-1:0] rdata;
	logic                  match;
	logic [DATA_WIDTH+VALUE_W-1:0] value_ext;
	logic [DATA_WIDTH+VALUE_W-1:0] rdata_ext;
	logic [CW+FILL_W-1:0]          fill_ext;

	// Circular index: the sum is always below twice the depth.
	function automatic logic [AW-1:0] wrap(input logic [SW-1:0] s);
		logic [SW-1:0] r;
		r = (s >= SW'(DEPTH)) ? (s - SW'(DEPTH)) : s;
		return r[AW-1:0];
	endfunction

	assign value_ext = {{DATA_WIDTH{1'b0}}, value_in};
	assign rdata_ext = {{VALUE_W{1'b0}}, rdata};

	assign front_m1 = (front_q == '0) ? AW'(DEPTH - 1) : (front_q - 1'b1);
	assign front_p1 = (front_q == AW'(DEPTH - 1)) ? '0 : (front_q + 1'b1);
	assign fc_sum   = {{(SW-AW){1'b0}}, front_q} + {1'b0, count_q};
	assign fi_sum   = {{(SW-AW){1'b0}}, front_q} + {1'b0, idx_q};

	always_comb begin
		case (cmd.asel)
			ASEL_FRONT_M1: addr = front_m1;
			ASEL_BACK_P1:  addr = wrap(fc_sum);
			ASEL_FRONT:    addr = front_q;
			ASEL_BACK:     addr = wrap(fc_sum - 1'b1);
			ASEL_SEARCH:   addr = wrap(fi_sum);
			default:       addr = front_q;
		endcase
	end

	always_comb begin
		front_d = front_q;
		count_d = count_q;
		case (cmd.upd)
			UPD_PUSH_F: begin
				front_d = front_m1;
				count_d = count_q + 1'b1;
			end
			UPD_PUSH_B: count_d = count_q + 1'b1;
			UPD_POP_F: begin
				front_d = front_p1;
				count_d = count_q - 1'b1;
			end
			UPD_POP_B: count_d = count_q - 1'b1;
			default: ;
		endcase
	end

	assign fill_ext = {{FILL_W{1'b0}}, count_d};

	deqs_ram #(
		.WIDTH (DATA_WIDTH),
		.DEPTH (DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (cmd.wr),
		.re    (cmd.rd),
		.addr  (addr),
		.wdata (value_q),
		.rdata (rdata)
	);

	assign match = (rdata == value_q);

	assign stat.op       = op_q;
	assign stat.empty    = (count_q == '0);
	assign stat.full     = (count_q == CW'(DEPTH));
	assign stat.match    = match;
	assign stat.srch_end = (idx_q == count_q);
	assign stat.out_free = !out_valid || out_ready;

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q    <= op_in;
			value_q <= value_ext[DATA_WIDTH-1:0];
		end
		if (cmd.emit) begin
			popped_value <= cmd.res_pop ? rdata_ext[VALUE_W-1:0] : '0;
			found        <= cmd.res_found && match;
			status       <= cmd.res_status;
			fill_level   <= fill_ext[FILL_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			front_q   <= '0;
			count_q   <= '0;
			idx_q     <= '0;
			out_valid <= 1'b0;
		end else begin
			front_q <= front_d;
			count_q <= count_d;
			if (cmd.load) begin
				idx_q <= '0;
			end else if (cmd.idx_inc) begin
				idx_q <= idx_q + 1'b1;
			end
			if (cmd.emit) begin
				out_valid <= 1'b1;
			end else if (out_ready) begin
				out_valid <= 1'b0;
			end
		end
	end

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(DEPTH))
		else $error("entry count exceeds the depth");

	a_no_write_full: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.wr |-> (count_q != CW'(DEPTH)))
		else $error("store written while full");

	a_pop_not_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.emit && cmd.res_pop) |-> (count_q != '0))
		else $error("pop result from an empty queue");

	a_search_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.idx_inc |-> (idx_q < count_q))
		else $error("search read beyond the valid entries");

endmodule

@@ hw/rtl/double_ended_queue_with_search_top.sv @@
// Channel  | Direction | Signals                      | Contents
// ---------+-----------+------------------------------+------------------------------------
// s_axis   | in        | tvalid, tready, tdata[39:0]  | one request: command and value
// m_axis   | out       | tvalid, tready, tdata[39:0]  | one result per request
//
// A push, an error result or an unused command passes from the idle state to the execute
// state and back; a pop also passes through a pop state, because the store has one port
// with a registered read. A contains request reads one stored entry per cycle through that
// same port while it stays in the search state, and stops early at the first match.
// Reset is asynchronous and active low; it empties the queue. The store itself is not cleared.
// A result waits in the output register while m_axis_tready is low; the next request is
// still accepted and runs until it must deliver its own result.
module double_ended_queue_with_search_top #(
	parameter int DEPTH      = 16,
	parameter int DATA_WIDTH = 32
) (
	input  logic                               clk,
	input  logic                               arst_n,
	// Request stream. tdata fields from bit 0: command[2:0], value[34:3], zero fill[39:35].
	input  logic                               s_axis_tvalid,
	output logic                               s_axis_tready,
	input  logic [deqs_pkg::S_TDATA_W-1:0]     s_axis_tdata,
	// Result stream. tdata fields from bit 0: popped_value[31:0], found[32],
	// status[34:33], fill_level[39:35].
	output logic                               m_axis_tvalid,
	input  logic                               m_axis_tready,
	output logic [deqs_pkg::M_TDATA_W-1:0]     m_axis_tdata
);

	import deqs_pkg::*;

	deqs_cmd_t            cmd;
	deqs_stat_t           stat;
	logic [VALUE_W-1:0]   popped_value;
	logic                 found;
	logic [STATUS_W-1:0]  status;
	logic [FILL_W-1:0]    fill_level;

	// The controller sequences each request; the datapath holds the pointers, the store
	// and the output register.
	deqs_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.stat     (stat),
		.cmd      (cmd)
	);

	deqs_dp #(
		.DEPTH      (DEPTH),
		.DATA_WIDTH (DATA_WIDTH)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.op_in        (s_axis_tdata[CMD_W-1:0]),
		.value_in     (s_axis_tdata[CMD_W+VALUE_W-1:CMD_W]),
		.cmd          (cmd),
		.stat         (stat),
		.out_ready    (m_axis_tready),
		.out_valid    (m_axis_tvalid),
		.popped_value (popped_value),
		.found        (found),
		.status       (status),
		.fill_level   (fill_level)
	);

	// The result fields fill the output word exactly.
	assign m_axis_tdata = {fill_level, status, found, popped_value};

endmodule
